FILE: rtl/tcw_pkg.sv
// Shared constants, command codes and queue entry type for the text console writer.
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    // Field widths
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_W = 2 * CHAR_W;

    // Command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] COLOR_RESET  = 8'h0E;

    // Operation kinds after classification
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] OP_PUT     = 3'd0;
    localparam logic [KIND_W-1:0] OP_NEWLINE = 3'd1;
    localparam logic [KIND_W-1:0] OP_READ    = 3'd2;
    localparam logic [KIND_W-1:0] OP_CLEAR   = 3'd3;
    localparam logic [KIND_W-1:0] OP_NOP     = 3'd4;

    // Command queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] raddr;
        logic              rd_ok;
    } t_op;

endpackage

FILE: rtl/text_console_writer_core.sv
// A put, unused command or off-screen read loads the result register as it leaves the
// queue, an on-screen read after the registered store read, a put that scrolls after the
// one-read one-write row copy, and a clear after the zeroing pass of the store.
// Throughput: one plain put per cycle is queued while the queue is not full; execution is
// one command at a time. Reset (synchronous, active low) clears the cursor, sets the color
// to 0x0E and zeroes all CELL_COUNT (2000) cells of the store, stalling input meanwhile.
module text_console_writer_core
    import tcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CHAR_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [ROW_W-1:0]  i_read_row,
    input  logic [COL_W-1:0]  i_read_col,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CHAR_W-1:0] o_cell_char,
    output logic [CHAR_W-1:0] o_cell_color,
    output logic [COL_W-1:0]  o_cursor_col,
    output logic [ROW_W-1:0]  o_cursor_row,
    output logic              o_scrolled
);

    logic push;
    t_op  push_op;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_op  q_op;
    logic init_busy;

    tcw_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_char_code (i_char_code),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .i_q_full    (q_full),
        .i_init_busy (init_busy),
        .o_push      (push),
        .o_op        (push_op)
    );

    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_op    (q_op)
    );

    tcw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_q_valid    (q_valid),
        .i_op         (q_op),
        .o_pop        (q_pop),
        .o_init_busy  (init_busy),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cell_char  (o_cell_char),
        .o_cell_color (o_cell_color),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_scrolled   (o_scrolled)
    );

endmodule

FILE: rtl/tcw_front.sv
// Front end: accepts command beats and classifies them into queue entries.
module tcw_front
    import tcw_pkg::*;
(
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [ROW_W-1:0]  i_read_row,
    input  logic [COL_W-1:0]  i_read_col,
    input  logic              i_q_full,
    input  logic              i_init_busy,
    output logic              o_push,
    output t_op               o_op
);

    // Hold off while the queue is full or the store is being cleared after reset
    assign o_in_stall = i_q_full || i_init_busy;
    assign o_push     = i_in_valid && !o_in_stall;

    // Classify the command and precompute the read address
    always_comb begin
        o_op.ch    = i_char_code;
        o_op.raddr = ADDR_W'(ADDR_W'(i_read_row) * ADDR_W'(COLUMNS))
                   + ADDR_W'(i_read_col);
        o_op.rd_ok = (32'(i_read_row) < ROWS) && (32'(i_read_col) < COLUMNS);
        case (i_cmd)
            CMD_PUT: begin
                o_op.kind = (i_char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
            end
            CMD_READ:  o_op.kind = OP_READ;
            CMD_CLEAR: o_op.kind = OP_CLEAR;
            default:   o_op.kind = OP_NOP;
        endcase
    end

endmodule

FILE: rtl/tcw_queue.sv
// Short command queue between the front end and the execution back end.
module tcw_queue
    import tcw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_op  o_op
);

    t_op              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue read while empty");
`endif

endmodule

FILE: rtl/tcw_back.sv
// Back end: cell store, cursor, scroll and clear sweeps, and the result register.
module tcw_back
    import tcw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CHAR_W-1:0] i_cfg_wdata,
    input  logic              i_q_valid,
    input  t_op               i_op,
    output logic              o_pop,
    output logic              o_init_busy,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CHAR_W-1:0] o_cell_char,
    output logic [CHAR_W-1:0] o_cell_color,
    output logic [COL_W-1:0]  o_cursor_col,
    output logic [ROW_W-1:0]  o_cursor_row,
    output logic              o_scrolled
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_CLEAR  = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] LAST_SCROLL = ADDR_W'(CELL_COUNT - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);

    logic [CELL_W-1:0] r_mem [CELL_COUNT];
    logic [CELL_W-1:0] r_rdata;

    logic [2:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [CHAR_W-1:0] r_color;
    logic              r_pend;
    logic [ADDR_W-1:0] r_wa;

    logic              r_out_valid;
    logic [CHAR_W-1:0] r_cell_char, n_cell_char;
    logic [CHAR_W-1:0] r_cell_color, n_cell_color;
    logic [COL_W-1:0]  r_cursor_col;
    logic [ROW_W-1:0]  r_cursor_row;
    logic              r_scrolled, n_scrolled;

    logic              out_free;
    logic              load;
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [CELL_W-1:0] wd;
    logic              re;
    logic [ADDR_W-1:0] ra;
    logic [ADDR_W-1:0] cur_addr;
    logic              wrap;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_pop       = (r_state == ST_IDLE) && i_q_valid && out_free;
    assign o_init_busy = (r_state == ST_INIT);
    assign cur_addr    = ADDR_W'(ADDR_W'(r_row) * ROW_STRIDE) + ADDR_W'(r_col);
    assign wrap        = (r_col == LAST_COL) || (i_op.kind == OP_NEWLINE);

    // Sequencer: cursor update, sweeps and result loading
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_col        = r_col;
        n_row        = r_row;
        load         = 1'b0;
        n_cell_char  = '0;
        n_cell_color = '0;
        n_scrolled   = 1'b0;
        re           = 1'b0;
        ra           = i_op.raddr;
        we           = 1'b0;
        wa           = r_wa;
        wd           = r_rdata;
        case (r_state)
            ST_INIT, ST_CLEAR: begin
                we    = 1'b1;
                wa    = r_cnt;
                wd    = '0;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_CELL) begin
                    n_state = ST_IDLE;
                    load    = (r_state == ST_CLEAR);
                end
            end
            ST_IDLE: begin
                if (o_pop) begin
                    case (i_op.kind)
                        OP_PUT, OP_NEWLINE: begin
                            if (i_op.kind == OP_PUT) begin
                                we = 1'b1;
                                wa = cur_addr;
                                wd = {r_color, i_op.ch};
                            end
                            n_col = r_col + 1'b1;
                            if (wrap) begin
                                n_col = '0;
                                if (r_row == LAST_ROW) begin
                                    n_cnt   = '0;
                                    n_state = ST_SCROLL;
                                end else begin
                                    n_row = r_row + 1'b1;
                                    load  = 1'b1;
                                end
                            end else begin
                                load = 1'b1;
                            end
                        end
                        OP_READ: begin
                            if (i_op.rd_ok) begin
                                re      = 1'b1;
                                n_state = ST_READ;
                            end else begin
                                load = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_cnt   = '0;
                            n_state = ST_CLEAR;
                        end
                        default: load = 1'b1;
                    endcase
                end
            end
            ST_READ: begin
                load         = 1'b1;
                n_cell_char  = r_rdata[CHAR_W-1:0];
                n_cell_color = r_rdata[CELL_W-1:CHAR_W];
                n_state      = ST_IDLE;
            end
            ST_SCROLL: begin
                // read one row ahead; the matching write follows in the next cycle
                re    = 1'b1;
                ra    = r_cnt + ROW_STRIDE;
                we    = r_pend;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_SCROLL) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                we         = r_pend;
                load       = 1'b1;
                n_scrolled = 1'b1;
                n_state    = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Cell store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (re) begin
            r_rdata <= r_mem[ra];
        end
        r_wa <= ra - ROW_STRIDE;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_cnt       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_color     <= COLOR_RESET;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_col   <= n_col;
            r_row   <= n_row;
            r_pend  <= (r_state == ST_SCROLL);
            if (i_cfg_we) begin
                r_color <= i_cfg_wdata;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cell_char  <= n_cell_char;
            r_cell_color <= n_cell_color;
            r_cursor_col <= n_col;
            r_cursor_row <= n_row;
            r_scrolled   <= n_scrolled;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_char  = r_cell_char;
    assign o_cell_color = r_cell_color;
    assign o_cursor_col = r_cursor_col;
    assign o_cursor_row = r_cursor_row;
    assign o_scrolled   = r_scrolled;

`ifndef SYNTH
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_col) < COLUMNS) && (32'(r_row) < ROWS))
        else $error("cursor outside the screen");
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_scrolled) |-> (o_cursor_col == '0 && o_cursor_row == LAST_ROW))
        else $error("scroll result with cursor off the bottom row start");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> out_free)
        else $error("result loaded over an untaken result");
`endif

endmodule
